[hw/rtl/rsi_pkg.sv]
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int DIST_W   = 31;
    localparam int OC_W     = COORD_W + 1;
    localparam int A_W      = 2 * COORD_W;
    localparam int H_W      = A_W + 2;
    localparam int HMAG_W   = H_W - 1;
    localparam int Q_W      = A_W + 2;
    localparam int RR_W     = 2 * RADIUS_W;
    localparam int CMAG_W   = Q_W;
    localparam int MUL_W    = 66;
    localparam int HALF_W   = MUL_W / 2;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DISC_W   = 131;
    localparam int SQRT_W   = 66;
    localparam int NUM_W    = SQRT_W + 1;
    localparam int REM_W    = A_W + DIST_W;
    localparam int CMP_W    = (NUM_W + FRAC_BITS > REM_W) ? NUM_W + FRAC_BITS : REM_W;
    localparam int MT_W     = COORD_W + DIST_W;
    localparam int STEP_W   = MT_W + 1;
    localparam int NRM_W    = STEP_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OC_W-1:0]    t_oc;

    typedef struct packed {
        t_coord              origin_x;
        t_coord              origin_y;
        t_coord              origin_z;
        t_coord              dir_x;
        t_coord              dir_y;
        t_coord              dir_z;
        t_coord              center_x;
        t_coord              center_y;
        t_coord              center_z;
        logic [RADIUS_W-1:0] radius;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        t_coord            normal_x;
        t_coord            normal_y;
        t_coord            normal_z;
        logic              overflow;
    } t_rsp;

    typedef enum logic [1:0] {
        ROOT_HMAG_MINUS_S = 2'd0,
        ROOT_HMAG_PLUS_S  = 2'd1,
        ROOT_S_MINUS_HMAG = 2'd2
    } t_root_op;

    typedef struct packed {
        logic              miss;
        t_root_op          op;
        logic [HMAG_W-1:0] hmag;
        logic [A_W-1:0]    a;
        t_coord [2:0]      d;
        t_oc [2:0]         oc;
    } t_bctx;

    typedef struct packed {
        logic [DISC_W-1:0] disc;
        t_bctx             ctx;
    } t_fitem;

    function automatic logic [COORD_W-1:0] mag_coord(input t_coord v);
        return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] mag_oc(input t_oc v);
        return v[OC_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

endpackage

[hw/rtl/ray_sphere_intersect.sv]
// Channel   Direction  Handshake                     Payload
// request   in         i_req_valid / o_req_ready     i_req (rsi_pkg::t_req)
// result    out        o_rsp_valid / i_rsp_ready     o_rsp (rsi_pkg::t_rsp)
//
// One request is accepted every cycle while o_req_ready is high; it drops when the queue is full.
// The back pipeline holds 66 square-root stages and 31 divider stages.
// Reset clears only the valid bits, the queue pointers and the queue count; there is no clearing pass.
// A stalled result freezes the back part while the front keeps filling the 4-entry queue.
module ray_sphere_intersect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rsi_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output rsi_pkg::t_rsp o_rsp
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    rsi_pkg::t_fitem push_item;
    rsi_pkg::t_fitem head_item;

    rsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item)
    );

    rsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_item)
    );

    rsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

[hw/rtl/rsi_mul.sv]
module rsi_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rsi_pkg::MUL_W-1:0]  i_x,
    input  logic [rsi_pkg::MUL_W-1:0]  i_y,
    output logic [rsi_pkg::PROD_W-1:0] o_p
);

    localparam int HW = rsi_pkg::HALF_W;
    localparam int PW = rsi_pkg::PROD_W;

    logic [2*HW-1:0] r_pp_ll;
    logic [2*HW-1:0] r_pp_lh;
    logic [2*HW-1:0] r_pp_hl;
    logic [2*HW-1:0] r_pp_hh;
    logic [PW-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll <= i_x[HW-1:0] * i_y[HW-1:0];
            r_pp_lh <= i_x[HW-1:0] * i_y[2*HW-1:HW];
            r_pp_hl <= i_x[2*HW-1:HW] * i_y[HW-1:0];
            r_pp_hh <= i_x[2*HW-1:HW] * i_y[2*HW-1:HW];
            r_p     <= PW'(r_pp_ll) + (PW'(r_pp_lh) << HW) + (PW'(r_pp_hl) << HW)
                       + (PW'(r_pp_hh) << (2 * HW));
        end
    end

    assign o_p = r_p;

endmodule

[hw/rtl/rsi_front.sv]
module rsi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  rsi_pkg::t_req   i_req,
    input  logic            i_full,
    output logic            o_push,
    output rsi_pkg::t_fitem o_item
);

    localparam int N_ST = 7;

    typedef struct packed {
        logic                       hle0;
        logic                       c_gt0;
        logic                       c_lt0;
        logic                       a_zero;
        logic [rsi_pkg::HMAG_W-1:0] hmag;
        logic [rsi_pkg::A_W-1:0]    a;
        rsi_pkg::t_coord [2:0]      d;
        rsi_pkg::t_oc [2:0]         oc;
    } t_fctx;

    logic [N_ST-1:0] r_vld;
    logic            adv;

    rsi_pkg::t_coord [2:0] r_s1_d;
    rsi_pkg::t_oc [2:0]    r_s1_oc;
    logic [rsi_pkg::RADIUS_W-1:0] r_s1_r;

    logic [rsi_pkg::COORD_W-1:0] n_md [3];
    logic [rsi_pkg::COORD_W-1:0] n_moc [3];
    logic signed [rsi_pkg::A_W:0] n_doc [3];

    rsi_pkg::t_coord [2:0] r_s2_d;
    rsi_pkg::t_oc [2:0]    r_s2_oc;
    logic [rsi_pkg::A_W-1:0]        r_s2_dd [3];
    logic signed [rsi_pkg::A_W-1:0] r_s2_doc [3];
    logic [rsi_pkg::A_W-1:0]        r_s2_occ [3];
    logic [rsi_pkg::RR_W-1:0]       r_s2_rr;

    rsi_pkg::t_coord [2:0] r_s3_d;
    rsi_pkg::t_oc [2:0]    r_s3_oc;
    logic [rsi_pkg::A_W-1:0]        r_s3_a;
    logic signed [rsi_pkg::H_W-1:0] r_s3_h;
    logic [rsi_pkg::Q_W-1:0]        r_s3_q;
    logic [rsi_pkg::RR_W-1:0]       r_s3_rr;

    t_fctx n_ctx4;
    logic [rsi_pkg::CMAG_W-1:0] n_cmag;
    logic [rsi_pkg::Q_W-1:0]    rr_ext;
    t_fctx r_s4_ctx;
    t_fctx r_s5_ctx;
    t_fctx r_s6_ctx;
    logic [rsi_pkg::CMAG_W-1:0] r_s4_cmag;

    logic [rsi_pkg::PROD_W-1:0] h2;
    logic [rsi_pkg::PROD_W-1:0] ac;

    rsi_pkg::t_fitem n_item;
    rsi_pkg::t_fitem r_s7_item;

    assign adv         = !r_vld[N_ST-1] || !i_full;
    assign o_req_ready = adv;
    assign o_push      = r_vld[N_ST-1] && !i_full;
    assign o_item      = r_s7_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[N_ST-2:0], i_req_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_d     <= {i_req.dir_z, i_req.dir_y, i_req.dir_x};
            r_s1_oc[0] <= $signed({i_req.origin_x[rsi_pkg::COORD_W-1], i_req.origin_x})
                          - $signed({i_req.center_x[rsi_pkg::COORD_W-1], i_req.center_x});
            r_s1_oc[1] <= $signed({i_req.origin_y[rsi_pkg::COORD_W-1], i_req.origin_y})
                          - $signed({i_req.center_y[rsi_pkg::COORD_W-1], i_req.center_y});
            r_s1_oc[2] <= $signed({i_req.origin_z[rsi_pkg::COORD_W-1], i_req.origin_z})
                          - $signed({i_req.center_z[rsi_pkg::COORD_W-1], i_req.center_z});
            r_s1_r     <= i_req.radius;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_md[k]  = rsi_pkg::mag_coord(r_s1_d[k]);
            n_moc[k] = rsi_pkg::mag_oc(r_s1_oc[k]);
            n_doc[k] = $signed(r_s1_d[k]) * $signed(r_s1_oc[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_s2_dd[k]  <= n_md[k] * n_md[k];
                r_s2_doc[k] <= n_doc[k][rsi_pkg::A_W-1:0];
                r_s2_occ[k] <= n_moc[k] * n_moc[k];
            end
            r_s2_rr <= r_s1_r * r_s1_r;
            r_s2_d  <= r_s1_d;
            r_s2_oc <= r_s1_oc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_a  <= r_s2_dd[0] + r_s2_dd[1] + r_s2_dd[2];
            r_s3_h  <= rsi_pkg::H_W'(r_s2_doc[0]) + rsi_pkg::H_W'(r_s2_doc[1])
                       + rsi_pkg::H_W'(r_s2_doc[2]);
            r_s3_q  <= rsi_pkg::Q_W'(r_s2_occ[0]) + rsi_pkg::Q_W'(r_s2_occ[1])
                       + rsi_pkg::Q_W'(r_s2_occ[2]);
            r_s3_rr <= r_s2_rr;
            r_s3_d  <= r_s2_d;
            r_s3_oc <= r_s2_oc;
        end
    end

    always_comb begin
        rr_ext        = rsi_pkg::Q_W'(r_s3_rr);
        n_ctx4.hle0   = r_s3_h[rsi_pkg::H_W-1] || (r_s3_h == '0);
        n_ctx4.hmag   = r_s3_h[rsi_pkg::H_W-1] ? rsi_pkg::HMAG_W'(-r_s3_h)
                                                : rsi_pkg::HMAG_W'(r_s3_h);
        n_ctx4.c_gt0  = r_s3_q > rr_ext;
        n_ctx4.c_lt0  = r_s3_q < rr_ext;
        n_ctx4.a_zero = (r_s3_a == '0);
        n_ctx4.a      = r_s3_a;
        n_ctx4.d      = r_s3_d;
        n_ctx4.oc     = r_s3_oc;
        n_cmag        = n_ctx4.c_lt0 ? rr_ext - r_s3_q : r_s3_q - rr_ext;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_ctx  <= n_ctx4;
            r_s4_cmag <= n_cmag;
            r_s5_ctx  <= r_s4_ctx;
            r_s6_ctx  <= r_s5_ctx;
        end
    end

    rsi_mul u_mul_hh (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (rsi_pkg::MUL_W'(r_s4_ctx.hmag)),
        .i_y   (rsi_pkg::MUL_W'(r_s4_ctx.hmag)),
        .o_p   (h2)
    );

    rsi_mul u_mul_ac (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (rsi_pkg::MUL_W'(r_s4_ctx.a)),
        .i_y   (rsi_pkg::MUL_W'(r_s4_cmag)),
        .o_p   (ac)
    );

    always_comb begin
        n_item.disc = r_s6_ctx.c_gt0 ? rsi_pkg::DISC_W'(h2 - ac)
                                     : rsi_pkg::DISC_W'(h2 + ac);
        n_item.ctx.miss = r_s6_ctx.a_zero || (r_s6_ctx.c_gt0 && (h2 < ac))
                          || (!r_s6_ctx.hle0 && r_s6_ctx.c_gt0);
        if (r_s6_ctx.hle0 && !r_s6_ctx.c_lt0) begin
            n_item.ctx.op = rsi_pkg::ROOT_HMAG_MINUS_S;
        end else if (r_s6_ctx.hle0) begin
            n_item.ctx.op = rsi_pkg::ROOT_HMAG_PLUS_S;
        end else begin
            n_item.ctx.op = rsi_pkg::ROOT_S_MINUS_HMAG;
        end
        n_item.ctx.hmag = r_s6_ctx.hmag;
        n_item.ctx.a    = r_s6_ctx.a;
        n_item.ctx.d    = r_s6_ctx.d;
        n_item.ctx.oc   = r_s6_ctx.oc;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s7_item <= n_item;
        end
    end

endmodule

[hw/rtl/rsi_queue.sv]
module rsi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsi_pkg::t_fitem i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rsi_pkg::t_fitem o_data
);

    localparam int DEPTH = rsi_pkg::QUEUE_DEPTH;
    localparam int PW    = rsi_pkg::QPTR_W;
    localparam int CW    = rsi_pkg::QCNT_W;

    rsi_pkg::t_fitem r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("Request pushed into a full queue.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("Request popped from an empty queue.");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("Queue count beyond its depth.");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty) else $error("Pushed request was lost.");
`endif

endmodule

[hw/rtl/rsi_back.sv]
module rsi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  rsi_pkg::t_fitem i_item,
    output logic            o_pop,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output rsi_pkg::t_rsp   o_rsp
);

    localparam int SW      = rsi_pkg::SQRT_W;
    localparam int DW      = rsi_pkg::DIST_W;
    localparam int TRIAL_W = rsi_pkg::DISC_W + 1;
    localparam int ST_NUM  = SW + 1;
    localparam int ST_DV0  = ST_NUM + 1;
    localparam int ST_MUL  = ST_DV0 + DW + 1;
    localparam int ST_STEP = ST_MUL + 1;
    localparam int ST_OUT  = ST_STEP + 1;
    localparam int N_ST    = ST_OUT + 1;
    localparam int CW      = rsi_pkg::COORD_W;
    localparam int NW      = rsi_pkg::NRM_W;

    typedef struct packed {
        logic                  miss;
        rsi_pkg::t_coord [2:0] d;
        rsi_pkg::t_oc [2:0]    oc;
    } t_nctx;

    logic [N_ST-1:0] r_vld;
    logic            adv;

    logic [rsi_pkg::DISC_W-1:0] r_sq_rem [SW+1];
    logic [SW-1:0]              r_sq_res [SW+1];
    rsi_pkg::t_bctx             r_sq_ctx [SW+1];

    logic [rsi_pkg::NUM_W-1:0] n_num;
    logic [rsi_pkg::NUM_W-1:0] r_num;
    logic [rsi_pkg::A_W-1:0]   r_num_a;
    t_nctx                     r_num_ctx;

    logic [rsi_pkg::CMP_W-1:0] num_ext;
    logic [rsi_pkg::CMP_W-1:0] a_ext;
    logic                      n_sat;

    logic [rsi_pkg::REM_W-1:0] r_dv_rem [DW+1];
    logic [DW-1:0]             r_dv_q [DW+1];
    logic [rsi_pkg::A_W-1:0]   r_dv_a [DW+1];
    logic                      r_dv_sat [DW+1];
    t_nctx                     r_dv_ctx [DW+1];

    logic [DW-1:0]            n_t;
    logic [DW-1:0]            r_mt_t;
    logic [rsi_pkg::MT_W-1:0] r_mt_m [3];
    logic                     r_mt_sat;
    t_nctx                    r_mt_ctx;

    logic signed [rsi_pkg::STEP_W-1:0] n_step [3];
    logic signed [rsi_pkg::STEP_W-1:0] r_st_step [3];
    logic [DW-1:0]                     r_st_t;
    logic                              r_st_sat;
    t_nctx                             r_st_ctx;

    logic signed [NW-1:0] nrm [3];
    logic [CW-1:0]        nrm_sat [3];
    logic [2:0]           nrm_ovf;
    rsi_pkg::t_rsp        n_rsp;
    rsi_pkg::t_rsp        r_rsp;

    assign adv         = !r_vld[N_ST-1] || i_rsp_ready;
    assign o_pop       = adv && !i_empty;
    assign o_rsp_valid = r_vld[N_ST-1];
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[N_ST-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0] <= i_item.disc;
            r_sq_res[0] <= '0;
            r_sq_ctx[0] <= i_item.ctx;
        end
    end

    for (genvar i = 0; i < SW; i++) begin : g_sqrt
        localparam int K = SW - 1 - i;
        logic [TRIAL_W-1:0] trial;
        logic               take;

        always_comb begin
            trial = (TRIAL_W'(r_sq_res[i]) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
            take  = {1'b0, r_sq_rem[i]} >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[i+1] <= take ? rsi_pkg::DISC_W'({1'b0, r_sq_rem[i]} - trial)
                                      : r_sq_rem[i];
                r_sq_res[i+1] <= take ? (r_sq_res[i] | (SW'(1) << K)) : r_sq_res[i];
                r_sq_ctx[i+1] <= r_sq_ctx[i];
            end
        end
    end

    always_comb begin
        case (r_sq_ctx[SW].op)
            rsi_pkg::ROOT_HMAG_MINUS_S: begin
                n_num = (r_sq_ctx[SW].hmag >= r_sq_res[SW])
                        ? rsi_pkg::NUM_W'(r_sq_ctx[SW].hmag) - rsi_pkg::NUM_W'(r_sq_res[SW])
                        : '0;
            end
            rsi_pkg::ROOT_HMAG_PLUS_S: begin
                n_num = rsi_pkg::NUM_W'(r_sq_ctx[SW].hmag) + rsi_pkg::NUM_W'(r_sq_res[SW]);
            end
            rsi_pkg::ROOT_S_MINUS_HMAG: begin
                n_num = (r_sq_res[SW] >= r_sq_ctx[SW].hmag)
                        ? rsi_pkg::NUM_W'(r_sq_res[SW]) - rsi_pkg::NUM_W'(r_sq_ctx[SW].hmag)
                        : '0;
            end
            default: begin
                n_num = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num          <= n_num;
            r_num_a        <= r_sq_ctx[SW].a;
            r_num_ctx.miss <= r_sq_ctx[SW].miss;
            r_num_ctx.d    <= r_sq_ctx[SW].d;
            r_num_ctx.oc   <= r_sq_ctx[SW].oc;
        end
    end

    always_comb begin
        num_ext = rsi_pkg::CMP_W'(r_num) << rsi_pkg::FRAC_BITS;
        a_ext   = rsi_pkg::CMP_W'(r_num_a) << DW;
        n_sat   = num_ext >= a_ext;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_rem[0] <= n_sat ? '0 : rsi_pkg::REM_W'(num_ext);
            r_dv_q[0]   <= '0;
            r_dv_a[0]   <= r_num_a;
            r_dv_sat[0] <= n_sat;
            r_dv_ctx[0] <= r_num_ctx;
        end
    end

    for (genvar j = 0; j < DW; j++) begin : g_div
        localparam int B = DW - 1 - j;
        logic [rsi_pkg::REM_W-1:0] sub;
        logic                      take;

        always_comb begin
            sub  = rsi_pkg::REM_W'(r_dv_a[j]) << B;
            take = r_dv_rem[j] >= sub;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_rem[j+1] <= take ? r_dv_rem[j] - sub : r_dv_rem[j];
                r_dv_q[j+1]   <= take ? (r_dv_q[j] | (DW'(1) << B)) : r_dv_q[j];
                r_dv_a[j+1]   <= r_dv_a[j];
                r_dv_sat[j+1] <= r_dv_sat[j];
                r_dv_ctx[j+1] <= r_dv_ctx[j];
            end
        end
    end

    assign n_t = r_dv_sat[DW] ? rsi_pkg::DIST_MAX : r_dv_q[DW];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_mt_m[k] <= rsi_pkg::mag_coord(r_dv_ctx[DW].d[k]) * n_t;
            end
            r_mt_t   <= n_t;
            r_mt_sat <= r_dv_sat[DW];
            r_mt_ctx <= r_dv_ctx[DW];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_mt_ctx.d[k][CW-1]) begin
                n_step[k] = -$signed((rsi_pkg::STEP_W'(r_mt_m[k])
                            + rsi_pkg::STEP_W'((1 << rsi_pkg::FRAC_BITS) - 1))
                            >> rsi_pkg::FRAC_BITS);
            end else begin
                n_step[k] = $signed(rsi_pkg::STEP_W'(r_mt_m[k] >> rsi_pkg::FRAC_BITS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st_step <= n_step;
            r_st_t    <= r_mt_t;
            r_st_sat  <= r_mt_sat;
            r_st_ctx  <= r_mt_ctx;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k] = NW'($signed(r_st_ctx.oc[k])) + NW'(r_st_step[k]);
            nrm_ovf[k] = (nrm[k][NW-1:CW-1] != '0) && (nrm[k][NW-1:CW-1] != '1);
            if (!nrm_ovf[k]) begin
                nrm_sat[k] = nrm[k][CW-1:0];
            end else if (nrm[k][NW-1]) begin
                nrm_sat[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                nrm_sat[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
        if (r_st_ctx.miss) begin
            n_rsp = '0;
        end else begin
            n_rsp.hit      = 1'b1;
            n_rsp.distance = r_st_t;
            n_rsp.normal_x = nrm_sat[0];
            n_rsp.normal_y = nrm_sat[1];
            n_rsp.normal_z = nrm_sat[2];
            n_rsp.overflow = r_st_sat || (nrm_ovf != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef ASSERT_OFF
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.hit) |-> (o_rsp.distance == '0 && !o_rsp.overflow
        && o_rsp.normal_x == '0 && o_rsp.normal_y == '0 && o_rsp.normal_z == '0))
        else $error("Missed request carries a nonzero result.");
`endif

endmodule
